### design/rprg_pkg.sv
package rprg_pkg;

  // register file layout and field widths
  localparam int unsigned RegRoutes    = 4;
  localparam int unsigned RouteW       = 2;
  localparam int unsigned RateW        = 16;
  localparam int unsigned TimeW        = 32;
  localparam int unsigned IvW          = 10;
  localparam int unsigned PAddrW       = 5;
  localparam int unsigned PDataW       = 32;
  localparam int unsigned NumRoutesDef = 4;

  // interval is this many ms divided by the route rate
  localparam logic [IvW-1:0]   MsPerSec   = 10'd1000;
  localparam logic [TimeW-1:0] NoDeadline = '1;

  typedef enum logic [2:0] {
    REG_ENABLE = 3'd0,
    REG_RATE0  = 3'd1,
    REG_RATE1  = 3'd2,
    REG_RATE2  = 3'd3,
    REG_RATE3  = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_SCAN,
    ST_REPORT
  } state_e;

  typedef struct packed {
    logic             func;
    logic [TimeW-1:0] now_ms;
    logic [RateW-1:0] loop_freq_hz;
  } in_item_t;

  typedef struct packed {
    logic [RouteW-1:0] route_index;
    logic              route_read;
    logic [TimeW-1:0]  next_deadline_ms;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic              take_item;
    logic              run_step;
    logic              scan_step;
    logic              report;
    logic [RouteW-1:0] idx;
    logic              last_route;
  } rprg_cmd_t;

  typedef struct packed {
    logic cfg_busy;
  } rprg_status_t;

endpackage

### design/rprg_div.sv
module rprg_div import rprg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RateW-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [IvW-1:0]   quot_o
);

  localparam int unsigned CntW = $clog2(IvW + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [RateW-1:0] div_q, div_d;
  logic [RateW-1:0] rem_q, rem_d;
  logic [IvW-1:0]   num_q, num_d;
  logic [IvW-1:0]   quot_q, quot_d;
  logic [RateW:0]   trial;
  logic             ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, num_q[IvW-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    div_d  = div_q;
    rem_d  = rem_q;
    num_d  = num_q;
    quot_d = quot_q;
    if (start_i && (cnt_q == '0)) begin
      cnt_d  = CntW'(IvW);
      div_d  = divisor_i;
      rem_d  = '0;
      num_d  = MsPerSec;
      quot_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CntW'(1);
      done_d = (cnt_q == CntW'(1));
      rem_d  = ge ? RateW'(trial - {1'b0, div_q}) : trial[RateW-1:0];
      num_d  = {num_q[IvW-2:0], 1'b0};
      quot_d = {quot_q[IvW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q  <= div_d;
    rem_q  <= rem_d;
    num_q  <= num_d;
    quot_q <= quot_d;
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### design/rprg_dp.sv
module rprg_dp import rprg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rprg_cmd_t         cmd_i,
  output rprg_status_t      status_o,
  input  in_item_t          in_item_i,
  output out_item_t         out_item_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [PDataW-1:0] pwdata,
  output logic [PDataW-1:0] prdata
);

  logic [RegRoutes-1:0] enable_q, enable_d;
  logic [RateW-1:0]     rate_q [RegRoutes];
  logic [RateW-1:0]     rate_d [RegRoutes];
  logic [IvW-1:0]       iv_q   [RegRoutes];
  logic [TimeW-1:0]     stamp_q [RegRoutes];
  logic [RegRoutes-1:0] dirty_q, dirty_d;
  logic [RouteW-1:0]    cur_q, cur_d;
  logic [RouteW-1:0]    pick;

  logic [TimeW-1:0] now_q;
  logic [RateW-1:0] loop_q;
  logic [TimeW-1:0] best_q, best_d;
  out_item_t        out_q, out_d;

  logic             wr_en;
  reg_idx_e         sel;
  logic             div_start, div_busy, div_done;
  logic [IvW-1:0]   div_quot;

  logic [TimeW-1:0] elapsed;
  logic             due, en, rate_nz;
  logic             skip, read;
  logic [IvW-1:0]   cand;
  logic [IvW-1:0]   r_iv;
  logic [TimeW-1:0] r_stamp;
  logic [RateW-1:0] r_rate;

  assign wr_en = psel && penable && pwrite;
  assign sel   = reg_idx_e'(paddr[4:2]);

  always_comb begin
    enable_d = enable_q;
    rate_d   = rate_q;
    if (wr_en) begin
      unique case (sel)
        REG_ENABLE: enable_d  = pwdata[RegRoutes-1:0];
        REG_RATE0:  rate_d[0] = pwdata[RateW-1:0];
        REG_RATE1:  rate_d[1] = pwdata[RateW-1:0];
        REG_RATE2:  rate_d[2] = pwdata[RateW-1:0];
        REG_RATE3:  rate_d[3] = pwdata[RateW-1:0];
        default:    enable_d  = enable_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (sel)
      REG_ENABLE: prdata = PDataW'(enable_q);
      REG_RATE0:  prdata = PDataW'(rate_q[0]);
      REG_RATE1:  prdata = PDataW'(rate_q[1]);
      REG_RATE2:  prdata = PDataW'(rate_q[2]);
      REG_RATE3:  prdata = PDataW'(rate_q[3]);
      default:    prdata = '0;
    endcase
  end

  // each rate write queues a divide to refresh that route's interval
  always_comb begin
    pick = '0;
    for (int i = RegRoutes - 1; i >= 0; i--) begin
      if (dirty_q[i]) pick = RouteW'(i);
    end
  end

  assign div_start = (dirty_q != '0) && !div_busy;

  always_comb begin
    dirty_d = dirty_q;
    cur_d   = cur_q;
    if (div_start) begin
      dirty_d[pick] = 1'b0;
      cur_d         = pick;
    end
    if (wr_en) begin
      unique case (sel)
        REG_RATE0: dirty_d[0] = 1'b1;
        REG_RATE1: dirty_d[1] = 1'b1;
        REG_RATE2: dirty_d[2] = 1'b1;
        REG_RATE3: dirty_d[3] = 1'b1;
        default:   dirty_d    = dirty_d;
      endcase
    end
  end

  rprg_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (rate_q[pick]),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign status_o.cfg_busy = (dirty_q != '0) || div_busy || div_done;

  // per-route evaluation at the walk index
  assign en      = enable_q[cmd_i.idx];
  assign r_rate  = rate_q[cmd_i.idx];
  assign r_iv    = iv_q[cmd_i.idx];
  assign r_stamp = stamp_q[cmd_i.idx];
  assign rate_nz = (r_rate != '0);
  assign elapsed = now_q - r_stamp;
  assign due     = (elapsed[TimeW-1:IvW] != '0) || (elapsed[IvW-1:0] >= r_iv);

  assign skip = rate_nz && (loop_q != '0) && (r_rate < loop_q) && (r_stamp != '0) && !due;
  assign read = en && !skip;

  always_comb begin
    if (!rate_nz || (r_stamp == '0) || due) cand = '0;
    else cand = r_iv - elapsed[IvW-1:0];
  end

  always_comb begin
    best_d = best_q;
    out_d  = out_q;
    if (cmd_i.take_item) best_d = NoDeadline;
    if (cmd_i.scan_step && en && (TimeW'(cand) < best_q)) best_d = TimeW'(cand);
    if (cmd_i.run_step) begin
      out_d.route_index      = cmd_i.idx;
      out_d.route_read       = read;
      out_d.next_deadline_ms = '0;
      out_d.last             = cmd_i.last_route;
    end else if (cmd_i.report) begin
      out_d.route_index      = '0;
      out_d.route_read       = 1'b0;
      out_d.next_deadline_ms = best_q;
      out_d.last             = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
      dirty_q  <= '0;
      cur_q    <= '0;
      for (int i = 0; i < RegRoutes; i++) begin
        rate_q[i]  <= '0;
        iv_q[i]    <= IvW'(1);
        stamp_q[i] <= '0;
      end
    end else begin
      enable_q <= enable_d;
      dirty_q  <= dirty_d;
      cur_q    <= cur_d;
      rate_q   <= rate_d;
      if (div_done) iv_q[cur_q] <= (div_quot == '0) ? IvW'(1) : div_quot;
      if (cmd_i.run_step && read) stamp_q[cmd_i.idx] <= now_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      now_q  <= in_item_i.now_ms;
      loop_q <= in_item_i.loop_freq_hz;
    end
    best_q <= best_d;
    out_q  <= out_d;
  end

  assign out_item_o = out_q;

endmodule

### design/rprg_ctrl.sv
module rprg_ctrl import rprg_pkg::*; #(
  parameter int unsigned ROUTES = NumRoutesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         in_func_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  rprg_status_t status_i,
  output rprg_cmd_t    cmd_o
);

  localparam int unsigned NumR = (ROUTES > RegRoutes) ? RegRoutes : ROUTES;
  localparam logic [RouteW-1:0] LastIdx = RouteW'(NumR - 1);

  state_e            state_q, state_d;
  logic [RouteW-1:0] idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  logic              slot_free;
  logic              at_last;

  assign slot_free = !out_valid_q || out_ready_i;
  assign at_last   = (idx_q == LastIdx);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (cmd_o.take_item) state_d = in_func_i ? ST_SCAN : ST_RUN;
      ST_RUN:    if (slot_free && at_last) state_d = ST_IDLE;
      ST_SCAN:   if (at_last) state_d = ST_REPORT;
      ST_REPORT: if (slot_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    cmd_o.idx       = idx_q;
    cmd_o.last_route = at_last;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = !status_i.cfg_busy;
        cmd_o.take_item = in_valid_i && !status_i.cfg_busy;
      end
      ST_RUN:    cmd_o.run_step  = slot_free;
      ST_SCAN:   cmd_o.scan_step = 1'b1;
      ST_REPORT: cmd_o.report    = slot_free;
      default:   cmd_o.report    = 1'b0;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_o.take_item) idx_d = '0;
    else if (cmd_o.run_step || cmd_o.scan_step) idx_d = at_last ? '0 : idx_q + RouteW'(1);
    if (cmd_o.run_step || cmd_o.report) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o)
    else $error("input taken while walking routes");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.run_step || cmd_o.report) |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before transfer");

  a_scan_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && at_last) |=> (state_q == ST_REPORT))
    else $error("query scan did not end in report");

  a_idx_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take_item |=> (idx_q == '0))
    else $error("route walk did not start at route zero");

endmodule

### design/route_poll_rate_gate.sv
// channel  | handshake                  | payload
// in       | in_valid_i / in_ready_o    | in_item_i  (func, now_ms, loop_freq_hz)
// out      | out_valid_o / out_ready_i  | out_item_o (route_index, route_read, ...)
// cfg      | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
// run item: once accepted, one result per route each unstalled cycle (up to 4 routes)
// query item: once accepted, one scan step per route, then one result
// a rate write queues a shared divide (1000 / rate), one quotient bit per cycle;
// rate writes hold in_ready_o low until every queued divide is done
// reset zeroes rates, enables and timestamps at once, sets intervals to 1; no sweep after reset
// out_ready_i low holds the result register and pauses a run item's route walk
module route_poll_rate_gate import rprg_pkg::*; #(
  parameter int unsigned ROUTES = NumRoutesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_item_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [PDataW-1:0] pwdata,
  output logic [PDataW-1:0] prdata,
  output logic              pready
);

  rprg_cmd_t    cmd;
  rprg_status_t status;

  assign pready = 1'b1;

  rprg_ctrl #(
    .ROUTES (ROUTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_func_i   (in_item_i.func),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rprg_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata)
  );

endmodule
